// ===== hw/rtl/qau_pkg.sv =====
// Quaternion arithmetic unit: shared types, operation codes and saturation helper.
// No dependencies; imported by every qau module.
`timescale 1ns / 1ps
package qau_pkg;

  localparam int WORD_W = 32;
  localparam int HAW    = WORD_W + 1;
  localparam int SATW   = 80;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_CONJ  = 4'd3,
    OP_DOT   = 4'd4,
    OP_SQMAG = 4'd5,
    OP_MAG   = 4'd6,
    OP_NORM  = 4'd7,
    OP_ROT   = 4'd8
  } op_t;

  typedef struct packed {
    op_t         op;
    word_t [3:0] l;
    word_t [3:0] q;
    word_t       s;
    logic        flag;
    logic        bypass;
  } item_t;

  typedef struct packed {
    word_t v;
    logic  clip;
  } sat_t;

  localparam logic signed [SATW-1:0] SAT_HI = SATW'(64'sh7FFF_FFFF);
  localparam logic signed [SATW-1:0] SAT_LO = -SAT_HI - SATW'(1);

  function automatic sat_t sat32(input logic signed [SATW-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.v    = word_t'(32'h7FFF_FFFF);
      r.clip = 1'b1;
    end else if (v < SAT_LO) begin
      r.v    = word_t'(32'h8000_0000);
      r.clip = 1'b1;
    end else begin
      r.v    = word_t'(v[WORD_W-1:0]);
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/qau_hamilton.sv =====
// Two-stage Hamilton product and dot product: 16 registered multiplies, then sums.
// Depends on qau_pkg.
`timescale 1ns / 1ps
module qau_hamilton import qau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  input  item_t                  item_i,
  input  logic signed [HAW-1:0]  a_i [4],
  input  logic signed [HAW-1:0]  b_i [4],
  output logic                   valid_o,
  output item_t                  item_o,
  output logic signed [2*HAW+1:0] r_o [4],
  output logic signed [2*HAW+1:0] dot_o
);

  localparam int PW = 2 * HAW;
  localparam int SW = 2 * HAW + 2;

  logic                 v1_r;
  item_t                it1_r;
  logic signed [PW-1:0] p_r [4][4];
  logic signed [SW-1:0] f [4][4];
  logic signed [SW-1:0] r_nxt [4];
  logic signed [SW-1:0] dot_nxt;
  logic                 v2_r;
  item_t                it2_r;
  logic signed [SW-1:0] r_r [4];
  logic signed [SW-1:0] dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    it1_r <= item_i;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p_r[i][j] <= PW'(a_i[i]) * PW'(b_i[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        f[i][j] = SW'(p_r[i][j] >>> FRAC_BITS);
      end
    end
    r_nxt[0] = f[3][0] + f[0][3] + f[1][2] - f[2][1];
    r_nxt[1] = f[3][1] + f[1][3] + f[2][0] - f[0][2];
    r_nxt[2] = f[3][2] + f[2][3] + f[0][1] - f[1][0];
    r_nxt[3] = f[3][3] - f[0][0] - f[1][1] - f[2][2];
    dot_nxt  = f[0][0] + f[1][1] + f[2][2] + f[3][3];
  end

  always_ff @(posedge clk) begin
    it2_r <= it1_r;
    dot_r <= dot_nxt;
    for (int i = 0; i < 4; i++) begin
      r_r[i] <= r_nxt[i];
    end
  end

  assign valid_o = v2_r;
  assign item_o  = it2_r;
  assign r_o     = r_r;
  assign dot_o   = dot_r;

endmodule

// ===== hw/rtl/qau_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, item carried alongside.
// Depends on qau_pkg.
`timescale 1ns / 1ps
module qau_sqrt import qau_pkg::*; #(
  parameter int RW = 47
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  input  item_t                   item_i,
  input  logic [RW-1:0]           rad_i,
  output logic                    valid_o,
  output item_t                   item_o,
  output logic [(RW+1)/2-1:0]     root_o
);

  localparam int RB  = (RW + 1) / 2;
  localparam int RP  = 2 * RB;
  localparam int RMW = RB + 2;
  localparam int TW  = RB + 4;

  logic           v_r    [RB];
  item_t          it_r   [RB];
  logic [RP-1:0]  rad_r  [RB];
  logic [RMW-1:0] rem_r  [RB];
  logic [RB-1:0]  root_r [RB];

  for (genvar k = 0; k < RB; k++) begin : g_st
    logic           v_in;
    item_t          it_in;
    logic [RP-1:0]  rad_in;
    logic [RMW-1:0] rem_in;
    logic [RB-1:0]  root_in;
    logic [TW-1:0]  tmp;
    logic [TW-1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign it_in   = item_i;
      assign rad_in  = RP'(rad_i);
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign it_in   = it_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign tmp   = {rem_in, rad_in[RP-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = tmp >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      it_r[k]   <= it_in;
      rad_r[k]  <= {rad_in[RP-3:0], 2'b00};
      rem_r[k]  <= ge ? RMW'(tmp - trial) : RMW'(tmp);
      root_r[k] <= {root_in[RB-2:0], ge};
    end
  end

  assign valid_o = v_r[RB-1];
  assign item_o  = it_r[RB-1];
  assign root_o  = root_r[RB-1];

endmodule

// ===== hw/rtl/qau_div.sv =====
// Four-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
// Depends on qau_pkg.
`timescale 1ns / 1ps
module qau_div import qau_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  item_t         item_i,
  input  logic [NW-1:0] num_i [4],
  input  logic [DW-1:0] den_i,
  output logic          valid_o,
  output item_t         item_o,
  output logic [NW-1:0] quo_o [4]
);

  logic          v_r   [NW];
  item_t         it_r  [NW];
  logic [DW-1:0] den_r [NW];
  logic [NW-1:0] nq_r  [NW][4];
  logic [DW-1:0] rem_r [NW][4];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic          v_in;
    item_t         it_in;
    logic [DW-1:0] den_in;
    logic [NW-1:0] nq_in  [4];
    logic [DW-1:0] rem_in [4];

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign it_in  = item_i;
      assign den_in = den_i;
      for (genvar n = 0; n < 4; n++) begin : g_ln
        assign nq_in[n]  = num_i[n];
        assign rem_in[n] = '0;
      end
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign it_in  = it_r[k-1];
      assign den_in = den_r[k-1];
      for (genvar n = 0; n < 4; n++) begin : g_ln
        assign nq_in[n]  = nq_r[k-1][n];
        assign rem_in[n] = rem_r[k-1][n];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
    end

    for (genvar n = 0; n < 4; n++) begin : g_lane
      logic [DW:0] tmp;
      logic        ge;

      assign tmp = {rem_in[n], nq_in[n][NW-1]};
      assign ge  = tmp >= {1'b0, den_in};

      always_ff @(posedge clk) begin
        rem_r[k][n] <= ge ? DW'(tmp - {1'b0, den_in}) : DW'(tmp);
        nq_r[k][n]  <= {nq_in[n][NW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      it_r[k]  <= it_in;
      den_r[k] <= den_in;
    end
  end

  assign valid_o = v_r[NW-1];
  assign item_o  = it_r[NW-1];
  for (genvar n = 0; n < 4; n++) begin : g_out
    assign quo_o[n] = nq_r[NW-1][n];
  end

endmodule

// ===== hw/rtl/quaternion_arithmetic_unit.sv =====
// Quaternion arithmetic unit top level: input register, two Hamilton stages,
// square root and divider pipelines, output register. Depends on qau_pkg and all qau modules.
// One item is taken every cycle (busy stays low). Every operation goes through the same
// pipeline, whose depth is set mostly by the bit-serial root and divider stages. Results
// come out in order, one strobe cycle each; the receiver cannot stall.
`timescale 1ns / 1ps
module quaternion_arithmetic_unit import qau_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        in_operation,
  input  logic signed [31:0] in_left_x,
  input  logic signed [31:0] in_left_y,
  input  logic signed [31:0] in_left_z,
  input  logic signed [31:0] in_left_w,
  input  logic signed [31:0] in_right_x,
  input  logic signed [31:0] in_right_y,
  input  logic signed [31:0] in_right_z,
  input  logic signed [31:0] in_right_w,
  output logic              out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic signed [31:0] out_scalar_result,
  output logic              out_saturated
);

  localparam int RW  = WORD_W - 1 + FRACTION_BITS;
  localparam int RB  = (RW + 1) / 2;
  localparam int NW  = WORD_W + FRACTION_BITS;
  localparam int SW  = 2 * HAW + 2;
  localparam int LAT = 8 + RB + NW;
  localparam logic [WORD_W-1:0] ONE_FX = WORD_W'(1) << FRACTION_BITS;

  logic                  in_v_r;
  op_t                   op_r;
  word_t [3:0]           l_r;
  word_t [3:0]           rr_r;

  item_t                 it0;
  logic signed [HAW-1:0] h1a [4];
  logic signed [HAW-1:0] h1b [4];
  sat_t                  sr0;

  logic                  h1_v;
  item_t                 h1_it;
  logic signed [SW-1:0]  h1_r [4];
  logic signed [SW-1:0]  h1_dot;
  item_t                 itc;
  sat_t                  src;
  logic                  c_v_r;
  item_t                 c_it_r;
  logic signed [HAW-1:0] h2a [4];
  logic signed [HAW-1:0] h2b [4];

  logic                  h2_v;
  item_t                 h2_it;
  logic signed [SW-1:0]  h2_r [4];
  item_t                 ite;
  sat_t                  sre;
  logic                  e_v_r;
  item_t                 e_it_r;
  logic [RW-1:0]         rad;

  logic                  sq_v;
  item_t                 sq_it;
  logic [RB-1:0]         root;
  item_t                 itf;
  logic [NW-1:0]         num [4];
  logic [RB-1:0]         den;
  logic [WORD_W-1:0]     mag_abs;

  logic                  dv_v;
  item_t                 dv_it;
  logic [NW-1:0]         quo [4];
  item_t                 ito;
  sat_t                  sro;
  logic signed [SATW-1:0] qv;

  logic                  out_v_r;
  item_t                 out_it_r;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_t'(in_operation);
    l_r[0]  <= in_left_x;
    l_r[1]  <= in_left_y;
    l_r[2]  <= in_left_z;
    l_r[3]  <= in_left_w;
    rr_r[0] <= in_right_x;
    rr_r[1] <= in_right_y;
    rr_r[2] <= in_right_z;
    rr_r[3] <= in_right_w;
  end

  // componentwise ops and multiplier operand select
  always_comb begin
    it0    = '0;
    it0.op = op_r;
    it0.l  = l_r;
    sr0    = '0;
    case (op_r)
      OP_ADD: begin
        for (int i = 0; i < 4; i++) begin
          sr0       = sat32(SATW'(signed'(l_r[i])) + SATW'(signed'(rr_r[i])));
          it0.q[i]  = sr0.v;
          it0.flag  = it0.flag | sr0.clip;
        end
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          sr0       = sat32(SATW'(signed'(l_r[i])) - SATW'(signed'(rr_r[i])));
          it0.q[i]  = sr0.v;
          it0.flag  = it0.flag | sr0.clip;
        end
      end
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) begin
          sr0       = sat32(-SATW'(signed'(l_r[i])));
          it0.q[i]  = sr0.v;
          it0.flag  = it0.flag | sr0.clip;
        end
        it0.q[3] = l_r[3];
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) begin
      h1a[i] = HAW'(signed'(l_r[i]));
      h1b[i] = HAW'(signed'(rr_r[i]));
    end
    case (op_r)
      OP_SQMAG, OP_MAG, OP_NORM: begin
        for (int i = 0; i < 4; i++) begin
          h1b[i] = HAW'(signed'(l_r[i]));
        end
      end
      OP_ROT: h1b[3] = '0;
      default: ;
    endcase
  end

  qau_hamilton #(.FRAC_BITS(FRACTION_BITS)) u_ham1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_v_r),
    .item_i  (it0),
    .a_i     (h1a),
    .b_i     (h1b),
    .valid_o (h1_v),
    .item_o  (h1_it),
    .r_o     (h1_r),
    .dot_o   (h1_dot)
  );

  // saturate product or dot result
  always_comb begin
    itc = h1_it;
    src = '0;
    case (h1_it.op)
      OP_MUL, OP_ROT: begin
        for (int i = 0; i < 4; i++) begin
          src      = sat32(SATW'(h1_r[i]));
          itc.q[i] = src.v;
          itc.flag = itc.flag | src.clip;
        end
      end
      OP_DOT, OP_SQMAG, OP_MAG, OP_NORM: begin
        src      = sat32(SATW'(h1_dot));
        itc.s    = src.v;
        itc.flag = itc.flag | src.clip;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else begin
      c_v_r <= h1_v;
    end
  end

  always_ff @(posedge clk) begin
    c_it_r <= itc;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h2a[i] = HAW'(signed'(c_it_r.q[i]));
    end
    for (int i = 0; i < 3; i++) begin
      h2b[i] = -HAW'(signed'(c_it_r.l[i]));
    end
    h2b[3] = HAW'(signed'(c_it_r.l[3]));
  end

  qau_hamilton #(.FRAC_BITS(FRACTION_BITS)) u_ham2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (c_v_r),
    .item_i  (c_it_r),
    .a_i     (h2a),
    .b_i     (h2b),
    .valid_o (h2_v),
    .item_o  (h2_it),
    .r_o     (h2_r),
    .dot_o   ()
  );

  // rotation result
  always_comb begin
    ite = h2_it;
    sre = '0;
    if (h2_it.op == OP_ROT) begin
      for (int i = 0; i < 3; i++) begin
        sre      = sat32(SATW'(h2_r[i]));
        ite.q[i] = sre.v;
        ite.flag = ite.flag | sre.clip;
      end
      ite.q[3] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else begin
      e_v_r <= h2_v;
    end
  end

  always_ff @(posedge clk) begin
    e_it_r <= ite;
  end

  assign rad = (e_it_r.op == OP_MAG || e_it_r.op == OP_NORM) ?
               {e_it_r.s[WORD_W-2:0], {FRACTION_BITS{1'b0}}} : '0;

  qau_sqrt #(.RW(RW)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (e_v_r),
    .item_i  (e_it_r),
    .rad_i   (rad),
    .valid_o (sq_v),
    .item_o  (sq_it),
    .root_o  (root)
  );

  // magnitude result, normalize pass-through check, divider operands
  always_comb begin
    itf     = sq_it;
    den     = (root == '0) ? RB'(1) : root;
    mag_abs = '0;
    for (int i = 0; i < 4; i++) begin
      mag_abs = sq_it.l[i][WORD_W-1] ? WORD_W'(-sq_it.l[i]) : WORD_W'(sq_it.l[i]);
      num[i]  = {mag_abs, {FRACTION_BITS{1'b0}}};
    end
    case (sq_it.op)
      OP_MAG: itf.s = word_t'(WORD_W'(root));
      OP_NORM: begin
        itf.s      = '0;
        itf.bypass = (sq_it.s == '0) || (sq_it.s == ONE_FX);
        if (itf.bypass) begin
          itf.q = sq_it.l;
        end
      end
      default: ;
    endcase
  end

  qau_div #(.NW(NW), .DW(RB)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (sq_v),
    .item_i  (itf),
    .num_i   (num),
    .den_i   (den),
    .valid_o (dv_v),
    .item_o  (dv_it),
    .quo_o   (quo)
  );

  // normalized components: sign, saturate
  always_comb begin
    ito = dv_it;
    sro = '0;
    qv  = '0;
    if (dv_it.op == OP_NORM && !dv_it.bypass) begin
      for (int i = 0; i < 4; i++) begin
        qv       = signed'(SATW'(quo[i]));
        qv       = dv_it.l[i][WORD_W-1] ? -qv : qv;
        sro      = sat32(qv);
        ito.q[i] = sro.v;
        ito.flag = ito.flag | sro.clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    out_it_r <= ito;
  end

  assign out_valid         = out_v_r;
  assign out_x             = out_it_r.q[0];
  assign out_y             = out_it_r.q[1];
  assign out_z             = out_it_r.q[2];
  assign out_w             = out_it_r.q[3];
  assign out_scalar_result = out_it_r.s;
  assign out_saturated     = out_it_r.flag;

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_valid)
    else $error("transfer did not reach the output at the fixed latency");

  a_scalar_excl : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scalar_result != '0 |->
      out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0)
    else $error("scalar result with nonzero quaternion");

endmodule

// ===== verif/quaternion_arithmetic_unit_tb.sv =====
// Testbench for quaternion_arithmetic_unit: directed and random quaternion operations,
// each result checked against a fixed-point predictor held in a small scoreboard class.
// Depends on qau_pkg and the quaternion_arithmetic_unit RTL.
`timescale 1ns / 1ps
module quaternion_arithmetic_unit_tb import qau_pkg::*;;

  localparam int FRAC = 16;
  localparam int WDOG_LIMIT = 5000;

  typedef struct packed {
    logic [3:0]  op;
    word_t [3:0] l;
    word_t [3:0] r;
  } quat_req_t;

  typedef struct packed {
    word_t [3:0] q;
    word_t       s;
    logic        flag;
  } quat_res_t;

  class quat_scoreboard;
    quat_res_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    static function longint fx_mul(longint a, longint b);
      return (a * b) >>> FRAC;
    endfunction

    static function word_t clip32(longint v, inout bit f);
      if (v > 64'sd2147483647) begin
        f = 1;
        return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
        f = 1;
        return 32'h8000_0000;
      end
      return word_t'(v);
    endfunction

    static function void hamilton(input longint a[4], input longint b[4],
                                  output longint p[4]);
      p[0] = fx_mul(a[3], b[0]) + fx_mul(a[0], b[3]) + fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]);
      p[1] = fx_mul(a[3], b[1]) + fx_mul(a[1], b[3]) + fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]);
      p[2] = fx_mul(a[3], b[2]) + fx_mul(a[2], b[3]) + fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]);
      p[3] = fx_mul(a[3], b[3]) - fx_mul(a[0], b[0]) - fx_mul(a[1], b[1]) - fx_mul(a[2], b[2]);
    endfunction

    static function longint int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    static function quat_res_t compute(quat_req_t req);
      longint a[4], b[4], t[4], cj[4], p[4];
      longint m, mag, sq;
      bit f;
      quat_res_t e;
      f = 0;
      e = '0;
      for (int i = 0; i < 4; i++) begin
        a[i] = longint'(req.l[i]);
        b[i] = longint'(req.r[i]);
      end
      sq = fx_mul(a[0], a[0]) + fx_mul(a[1], a[1]) + fx_mul(a[2], a[2]) + fx_mul(a[3], a[3]);
      case (req.op)
        OP_ADD: for (int i = 0; i < 4; i++) e.q[i] = clip32(a[i] + b[i], f);
        OP_SUB: for (int i = 0; i < 4; i++) e.q[i] = clip32(a[i] - b[i], f);
        OP_MUL: begin
          hamilton(a, b, t);
          for (int i = 0; i < 4; i++) e.q[i] = clip32(t[i], f);
        end
        OP_CONJ: begin
          for (int i = 0; i < 3; i++) e.q[i] = clip32(-a[i], f);
          e.q[3] = req.l[3];
        end
        OP_DOT: e.s = clip32(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1])
                             + fx_mul(a[2], b[2]) + fx_mul(a[3], b[3]), f);
        OP_SQMAG: e.s = clip32(sq, f);
        OP_MAG: begin
          m = longint'(clip32(sq, f));
          if (m > 0) e.s = word_t'(int_sqrt(m << FRAC));
        end
        OP_NORM: begin
          m = longint'(clip32(sq, f));
          if (m == 0 || m == (64'sd1 << FRAC)) begin
            e.q = req.l;
          end else begin
            mag = int_sqrt(m << FRAC);
            if (mag < 1) mag = 1;
            for (int i = 0; i < 4; i++) e.q[i] = clip32((a[i] * (64'sd1 << FRAC)) / mag, f);
          end
        end
        OP_ROT: begin
          b[3] = 0;
          hamilton(a, b, t);
          for (int i = 0; i < 4; i++) t[i] = longint'(clip32(t[i], f));
          cj[0] = -a[0]; cj[1] = -a[1]; cj[2] = -a[2]; cj[3] = a[3];
          hamilton(t, cj, p);
          for (int i = 0; i < 3; i++) e.q[i] = clip32(p[i], f);
        end
        default: ;
      endcase
      e.flag = f;
      return e;
    endfunction

    function void note_input(quat_req_t req);
      pending.push_back(compute(req));
    endfunction

    function void check_result(quat_res_t got);
      quat_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h w=%h s=%h sat=%b", $time,
                 got.q[0], got.q[1], got.q[2], got.q[3], got.s, got.flag);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 4; i++)
        if (got.q[i] !== e.q[i]) begin
          $display("%0t: component %0d expected %h actual %h", $time, i, e.q[i], got.q[i]);
          errors++;
        end
      if (got.s !== e.s) begin
        $display("%0t: scalar expected %h actual %h", $time, e.s, got.s);
        errors++;
      end
      if (got.flag !== e.flag) begin
        $display("%0t: saturated expected %b actual %b", $time, e.flag, got.flag);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_valid, out_saturated;
  logic [3:0] in_operation;
  logic signed [31:0] in_left_x, in_left_y, in_left_z, in_left_w;
  logic signed [31:0] in_right_x, in_right_y, in_right_z, in_right_w;
  logic signed [31:0] out_x, out_y, out_z, out_w, out_scalar_result;

  quat_scoreboard sb;
  int idle_pct;
  int wdog;

  quaternion_arithmetic_unit uut (.*);

  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      sb.note_input({in_operation, in_left_w, in_left_z, in_left_y, in_left_x,
                     in_right_w, in_right_z, in_right_y, in_right_x});
    if (rst_n && out_valid)
      sb.check_result({out_w, out_z, out_y, out_x, out_scalar_result, out_saturated});
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog == WDOG_LIMIT) begin
      $display("** quaternion_arithmetic_unit: FAILED **");
      $finish;
    end
  end

  task automatic send(quat_req_t req);
    bit taken;
    start <= 1;
    in_operation <= req.op;
    {in_left_w, in_left_z, in_left_y, in_left_x} <= req.l;
    {in_right_w, in_right_z, in_right_y, in_right_x} <= req.r;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
  endtask

  function automatic word_t rand_comp();
    case ($urandom_range(9))
      0: case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 0;
        default: return 32'hFFFF_FFFF;
      endcase
      1, 2: return $urandom;
      default: return word_t'($urandom_range(32'h60000)) - 32'sh30000;
    endcase
  endfunction

  function automatic quat_req_t rand_req();
    quat_req_t req;
    req.op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    for (int i = 0; i < 4; i++) begin
      req.l[i] = rand_comp();
      req.r[i] = rand_comp();
    end
    // unit-length left quaternion for the normalize pass-through case
    if (req.op == OP_NORM && $urandom_range(4) == 0) begin
      req.l = '0;
      req.l[$urandom_range(3)] = $urandom_range(1) ? 32'sh10000 : -32'sh10000;
    end
    return req;
  endfunction

  function automatic quat_req_t mk(op_t op, word_t lx, word_t ly, word_t lz, word_t lw,
                                   word_t rx, word_t ry, word_t rz, word_t rw);
    quat_req_t req;
    req.op = op;
    req.l = {lw, lz, ly, lx};
    req.r = {rw, rz, ry, rx};
    return req;
  endfunction

  localparam word_t MN = 32'h8000_0000;
  localparam word_t MX = 32'h7FFF_FFFF;
  localparam word_t ONE = 32'sh10000;

  initial begin
    sb = new();
    idle_pct = 0;
    rst_n = 0;
    start = 0;
    in_operation = 0;
    {in_left_x, in_left_y, in_left_z, in_left_w} = '0;
    {in_right_x, in_right_y, in_right_z, in_right_w} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(mk(OP_ADD, MX, MN, 1, -1, 1, -1, MX, MN));
    send(mk(OP_SUB, MN, MX, 0, 5, 1, -1, MN, MX));
    send(mk(OP_MUL, ONE, 2 * ONE, -ONE, ONE / 2, ONE, ONE, 3 * ONE, -ONE));
    send(mk(OP_MUL, MX, MX, MN, MN, MN, MX, MX, MN));
    send(mk(OP_CONJ, MN, MX, -1, MN, 0, 0, 0, 0));
    send(mk(OP_DOT, MX, MX, MX, MX, MX, MX, MX, MX));
    send(mk(OP_DOT, ONE, -ONE, ONE / 3, 7, ONE, ONE, ONE, ONE));
    send(mk(OP_SQMAG, MN, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_SQMAG, ONE, ONE, 0, 0, 0, 0, 0, 0));
    send(mk(OP_MAG, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_MAG, MX, MN, MX, MN, 0, 0, 0, 0));
    send(mk(OP_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0));
    send(mk(OP_MAG, 1, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_NORM, 0, 0, 0, 0, 1, 2, 3, 4));
    send(mk(OP_NORM, 0, 0, 0, ONE, 0, 0, 0, 0));
    send(mk(OP_NORM, 0, -ONE, 0, 0, 0, 0, 0, 0));
    send(mk(OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0));
    send(mk(OP_NORM, MX, MN, MX, MN, 0, 0, 0, 0));
    send(mk(OP_NORM, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0));
    send(mk(OP_ROT, 0, 0, 32'sh0B505, 32'sh0B505, ONE, 2 * ONE, -ONE, MX));
    send(mk(OP_ROT, MX, MN, MX, MN, MX, MN, MX, 0));
    send(mk(OP_ROT, 0, 0, 0, ONE, MN, MX, 5, MN));
    send(mk(op_t'(4'd9), MX, MX, MX, MX, MX, MX, MX, MX));
    send(mk(op_t'(4'd15), MN, MN, MN, MN, MN, MN, MN, MN));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 75;
        2: idle_pct = 0;
        default: idle_pct = 17;
      endcase
      for (int n = 0; n < 100; n++) send(rand_req());
      if (ph == 1) begin
        start <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        @(posedge clk);
      end
    end
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (sb.errors == 0)
      $display("** quaternion_arithmetic_unit: PASSED **");
    else
      $display("** quaternion_arithmetic_unit: FAILED **");
    $finish;
  end
endmodule
